/* sv/mcstp_pkg.sv */
// Shared types and constants for the soft timer pool.
package mcstp_pkg;

   localparam int OPCODE_BITS    = 2;
   localparam int CHANNEL_BITS   = 7;
   localparam int PERIOD_BITS    = 16;
   localparam int ALLOC_BITS     = 6;
   localparam int PRESCALE_BITS  = 8;
   localparam logic [PRESCALE_BITS-1:0] PRESCALE_RESET = 8'd100;

   typedef enum logic [OPCODE_BITS-1:0] {
      OP_TICK  = 2'd0,
      OP_ALLOC = 2'd1,
      OP_POLL  = 2'd2,
      OP_CLEAR = 2'd3
   } mcstp_op_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EXEC = 2'b10
   } mcstp_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic inval;
      logic clear_all;
   } mcstp_ram_ctl_type;

endpackage

/* sv/mcstp_count_ram.sv */
// Channel count memory with per-entry valid bits; invalid entries read as zero.
module mcstp_count_ram #(
   parameter int DEPTH     = 32,
   parameter int ADDR_BITS = 5,
   parameter int DATA_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  mcstp_pkg::mcstp_ram_ctl_type   ctl,
   input  logic [ADDR_BITS-1:0]           rd_addr,
   input  logic [ADDR_BITS-1:0]           wr_addr,
   input  logic [DATA_BITS-1:0]           wr_data,
   output logic [DATA_BITS-1:0]           rd_data
);
   import mcstp_pkg::*;

   logic [DATA_BITS-1:0] mem [DEPTH];
   logic [DATA_BITS-1:0] rd_q_ff;
   logic                 rd_valid_ff;
   logic [DEPTH-1:0]     valid_ff;
   logic [DEPTH-1:0]     valid_in;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (ctl.rd_en) begin
         rd_q_ff     <= mem[rd_addr];
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (ctl.clear_all) begin
         valid_in = '0;
      end else if (ctl.inval) begin
         valid_in[wr_addr] = 1'b0;
      end else if (ctl.wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

/* sv/mcstp_free_enc.sv */
// Lowest free channel finder over the in-use vector.
module mcstp_free_enc #(
   parameter int NUM_CHANNELS = 32,
   parameter int CH_BITS      = 5
) (
   input  logic [NUM_CHANNELS-1:0] in_use,
   output logic                    found,
   output logic [CH_BITS-1:0]      index
);
   import mcstp_pkg::*;

   always_comb begin
      found = 1'b0;
      index = '0;
      for (int k = NUM_CHANNELS - 1; k >= 0; k--) begin
         if (!in_use[k]) begin
            found = 1'b1;
            index = CH_BITS'(k);
         end
      end
   end

endmodule

/* sv/multi_channel_soft_timer_pool.sv */
// Soft timer pool: 32-channel timer with shared prescaler and count memory.
// rsp_strobe is registered: an accepting edge (start & !busy) moves the state to execute,
// which sets the strobe register; the receiver cannot stall.
// Commands are taken only while idle; busy is high for the one execute cycle in which
// the count memory read returns and the write-back happens. Reset (synchronous): control
// state clears, prescale_limit returns to 100, no clearing pass; results are not reset.
module multi_channel_soft_timer_pool #(
   parameter int NUM_CHANNELS = 32,
   parameter int COUNT_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [mcstp_pkg::OPCODE_BITS-1:0]    req_opcode,
   input  logic [mcstp_pkg::CHANNEL_BITS-1:0]   req_channel,
   input  logic                                 req_auto_clear,
   input  logic [mcstp_pkg::PERIOD_BITS-1:0]    req_period,
   output logic                                 rsp_strobe,
   output logic                                 rsp_fired,
   output logic [mcstp_pkg::ALLOC_BITS-1:0]     rsp_allocated_channel,
   input  logic                                 csr_wr_en,
   input  logic [mcstp_pkg::PRESCALE_BITS-1:0]  csr_wr_data
);
   import mcstp_pkg::*;

   localparam int CH_BITS  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
   localparam int CMP_BITS = (COUNT_BITS > PERIOD_BITS) ? COUNT_BITS : PERIOD_BITS;

   mcstp_state_type             state_ff, state_in;
   logic [PRESCALE_BITS-1:0]    limit_ff, limit_in;
   logic [PRESCALE_BITS-1:0]    presc_ff, presc_in;
   logic [NUM_CHANNELS-1:0]     pending_ff, pending_in;
   logic [NUM_CHANNELS-1:0]     in_use_ff, in_use_in;
   logic                        strobe_ff, strobe_in;
   logic                        fired_ff, fired_in;
   logic [ALLOC_BITS-1:0]       alloc_ff, alloc_in;

   mcstp_op_type                op_ff;
   logic [CHANNEL_BITS-1:0]     ch_ff;
   logic                        aclr_ff;
   logic [PERIOD_BITS-1:0]      period_ff;

   mcstp_ram_ctl_type           ram_ctl;
   logic [CH_BITS-1:0]          ram_wr_addr;
   logic [COUNT_BITS-1:0]       ram_wr_data;
   logic [COUNT_BITS-1:0]       ram_rd_data;

   logic                        free_found;
   logic [CH_BITS-1:0]          free_idx;

   logic                        accept;
   logic                        req_ch_ok;
   logic                        ch_ok;
   logic [NUM_CHANNELS-1:0]     ch_bit;
   logic [NUM_CHANNELS-1:0]     free_bit;
   logic [CMP_BITS-1:0]         period_w;
   logic [COUNT_BITS-1:0]       cnt_inc;

   assign busy      = (state_ff == ST_EXEC);
   assign accept    = start && !busy;
   assign req_ch_ok = req_channel < CHANNEL_BITS'(NUM_CHANNELS);
   assign ch_ok     = ch_ff < CHANNEL_BITS'(NUM_CHANNELS);
   assign ch_bit    = NUM_CHANNELS'(1) << ch_ff[CH_BITS-1:0];
   assign free_bit  = NUM_CHANNELS'(1) << free_idx;
   assign period_w  = CMP_BITS'(period_ff);

   mcstp_free_enc #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .CH_BITS      (CH_BITS)
   ) u_free_enc (
      .in_use (in_use_ff),
      .found  (free_found),
      .index  (free_idx)
   );

   mcstp_count_ram #(
      .DEPTH     (NUM_CHANNELS),
      .ADDR_BITS (CH_BITS),
      .DATA_BITS (COUNT_BITS)
   ) u_count_ram (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ram_ctl),
      .rd_addr (req_channel[CH_BITS-1:0]),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_data (ram_rd_data)
   );

   // advance the count while at or below the period; wrap at the count width
   always_comb begin
      if (CMP_BITS'(ram_rd_data) <= period_w) begin
         cnt_inc = ram_rd_data + COUNT_BITS'(1);
      end else begin
         cnt_inc = ram_rd_data;
      end
   end

   always_comb begin
      state_in    = state_ff;
      limit_in    = csr_wr_en ? csr_wr_data : limit_ff;
      presc_in    = presc_ff;
      pending_in  = pending_ff;
      in_use_in   = in_use_ff;
      strobe_in   = 1'b0;
      fired_in    = 1'b0;
      alloc_in    = '0;
      ram_ctl     = '0;
      ram_wr_addr = ch_ff[CH_BITS-1:0];
      ram_wr_data = cnt_inc;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               ram_ctl.rd_en = (mcstp_op_type'(req_opcode) == OP_POLL) && req_ch_ok;
               state_in      = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in  = ST_IDLE;
            strobe_in = 1'b1;
            unique case (op_ff)
               OP_TICK: begin
                  if (presc_ff >= limit_ff) begin
                     presc_in   = '0;
                     pending_in = '1;
                  end else begin
                     presc_in = presc_ff + PRESCALE_BITS'(1);
                  end
               end
               OP_ALLOC: begin
                  if (free_found) begin
                     alloc_in      = ALLOC_BITS'(free_idx);
                     in_use_in     = in_use_ff | free_bit;
                     ram_wr_addr   = free_idx;
                     ram_ctl.inval = 1'b1;
                  end else begin
                     alloc_in = ALLOC_BITS'(NUM_CHANNELS);
                  end
               end
               OP_POLL: begin
                  if (ch_ok) begin
                     in_use_in = in_use_ff | ch_bit;
                     if ((pending_ff & ch_bit) != '0) begin
                        pending_in    = pending_ff & ~ch_bit;
                        fired_in      = (CMP_BITS'(cnt_inc) == period_w);
                        ram_ctl.wr_en = 1'b1;
                        if ((CMP_BITS'(cnt_inc) >= period_w) && aclr_ff) begin
                           ram_wr_data = '0;
                        end
                     end
                  end
               end
               OP_CLEAR: begin
                  pending_in        = '0;
                  in_use_in         = '0;
                  ram_ctl.clear_all = 1'b1;
               end
               default: begin
                  strobe_in = 1'b1;
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         limit_ff   <= PRESCALE_RESET;
         presc_ff   <= '0;
         pending_ff <= '0;
         in_use_ff  <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         limit_ff   <= limit_in;
         presc_ff   <= presc_in;
         pending_ff <= pending_in;
         in_use_ff  <= in_use_in;
         strobe_ff  <= strobe_in;
      end
   end

   // hold the command beat and the result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= mcstp_op_type'(req_opcode);
         ch_ff     <= req_channel;
         aclr_ff   <= req_auto_clear;
         period_ff <= req_period;
      end
      if (strobe_in) begin
         fired_ff <= fired_in;
         alloc_ff <= alloc_in;
      end
   end

   assign rsp_strobe            = strobe_ff;
   assign rsp_fired             = fired_ff;
   assign rsp_allocated_channel = alloc_ff;

endmodule

/* dv/timer_pool_checker.sv */
// Checker for the soft timer pool: tracks pool state, predicts each response and compares.
`timescale 1ns / 100ps

module timer_pool_checker
   import mcstp_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic                     busy,
   input  logic [OPCODE_BITS-1:0]   req_opcode,
   input  logic [CHANNEL_BITS-1:0]  req_channel,
   input  logic                     req_auto_clear,
   input  logic [PERIOD_BITS-1:0]   req_period,
   input  logic                     rsp_strobe,
   input  logic                     rsp_fired,
   input  logic [ALLOC_BITS-1:0]    rsp_allocated_channel,
   input  logic                     csr_wr_en,
   input  logic [PRESCALE_BITS-1:0] csr_wr_data,
   output int                       fail_count,
   output int                       outstanding
);

   localparam int CHANNELS = 32;

   typedef struct packed {
      logic                  fired;
      logic [ALLOC_BITS-1:0] channel;
   } timer_result_type;

   logic [PRESCALE_BITS-1:0] limit_copy;
   logic [PRESCALE_BITS-1:0] prescale;
   logic [CHANNELS-1:0]      pending;
   logic [CHANNELS-1:0]      in_use;
   logic [PERIOD_BITS-1:0]   counts [CHANNELS];
   timer_result_type         results_due [$];
   timer_result_type         want;

   function automatic timer_result_type apply_command(input mcstp_op_type op,
                                                      input logic [CHANNEL_BITS-1:0] ch,
                                                      input logic ac,
                                                      input logic [PERIOD_BITS-1:0] per);
      timer_result_type       r;
      logic [PERIOD_BITS-1:0] c;
      logic                   found;
      int                     k;
      r = '0;
      case (op)
         OP_TICK: begin
            if (prescale >= limit_copy) begin
               prescale = '0;
               pending  = '1;
            end else begin
               prescale = prescale + 1'b1;
            end
         end
         OP_ALLOC: begin
            found     = 1'b0;
            r.channel = ALLOC_BITS'(CHANNELS);
            for (k = 0; k < CHANNELS; k++) begin
               if (!found && !in_use[k]) begin
                  found     = 1'b1;
                  in_use[k] = 1'b1;
                  counts[k] = '0;
                  r.channel = ALLOC_BITS'(k);
               end
            end
         end
         OP_POLL: begin
            if (ch < CHANNELS) begin
               in_use[ch[4:0]] = 1'b1;
               if (pending[ch[4:0]]) begin
                  pending[ch[4:0]] = 1'b0;
                  c = counts[ch[4:0]];
                  if (c <= per) c = c + 1'b1;
                  if (c == per) r.fired = 1'b1;
                  if (c >= per && ac) c = '0;
                  counts[ch[4:0]] = c;
               end
            end
         end
         default: begin
            pending = '0;
            in_use  = '0;
            for (k = 0; k < CHANNELS; k++) counts[k] = '0;
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fail_count = 0;
         limit_copy = PRESCALE_RESET;
         prescale   = '0;
         pending    = '0;
         in_use     = '0;
         foreach (counts[i]) counts[i] = '0;
         results_due.delete();
      end else begin
         if (rsp_strobe) begin
            if (results_due.size() == 0) begin
               $error("unexpected beat: fired %0d, allocated_channel %0d",
                      rsp_fired, rsp_allocated_channel);
               fail_count++;
            end else begin
               want = results_due.pop_front();
               if (rsp_fired !== want.fired) begin
                  $error("fired: expected %0d, actual %0d", want.fired, rsp_fired);
                  fail_count++;
               end
               if (rsp_allocated_channel !== want.channel) begin
                  $error("allocated_channel: expected %0d, actual %0d",
                         want.channel, rsp_allocated_channel);
                  fail_count++;
               end
            end
         end
         if (csr_wr_en) limit_copy = csr_wr_data;
         if (start && !busy)
            results_due.push_back(apply_command(mcstp_op_type'(req_opcode), req_channel,
                                                req_auto_clear, req_period));
      end
      outstanding = results_due.size();
   end

endmodule

/* dv/tb.sv */
// Testbench top for the soft timer pool: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module tb;
   import mcstp_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     start = 1'b0;
   logic                     busy;
   logic [OPCODE_BITS-1:0]   req_opcode = '0;
   logic [CHANNEL_BITS-1:0]  req_channel = '0;
   logic                     req_auto_clear = 1'b0;
   logic [PERIOD_BITS-1:0]   req_period = '0;
   logic                     rsp_strobe;
   logic                     rsp_fired;
   logic [ALLOC_BITS-1:0]    rsp_allocated_channel;
   logic                     csr_wr_en = 1'b0;
   logic [PRESCALE_BITS-1:0] csr_wr_data = '0;
   int                       fail_count;
   int                       outstanding;
   int                       stall_cycles = 0;

   multi_channel_soft_timer_pool i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_channel           (req_channel),
      .req_auto_clear        (req_auto_clear),
      .req_period            (req_period),
      .rsp_strobe            (rsp_strobe),
      .rsp_fired             (rsp_fired),
      .rsp_allocated_channel (rsp_allocated_channel),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data)
   );

   timer_pool_checker i_checker (
      .clock                 (clock),
      .reset                 (reset),
      .start                 (start),
      .busy                  (busy),
      .req_opcode            (req_opcode),
      .req_channel           (req_channel),
      .req_auto_clear        (req_auto_clear),
      .req_period            (req_period),
      .rsp_strobe            (rsp_strobe),
      .rsp_fired             (rsp_fired),
      .rsp_allocated_channel (rsp_allocated_channel),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .fail_count            (fail_count),
      .outstanding           (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || csr_wr_en) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic issue(input mcstp_op_type op, input logic [CHANNEL_BITS-1:0] ch,
                        input logic ac, input logic [PERIOD_BITS-1:0] per);
      req_opcode     <= op;
      req_channel    <= ch;
      req_auto_clear <= ac;
      req_period     <= per;
      start          <= 1'b1;
      forever begin
         @(negedge clock);
         if (!busy) break;
      end
      @(posedge clock);
   endtask

   // hold off until every beat has come back, then let the pipeline drain
   task automatic drain;
      start <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [PRESCALE_BITS-1:0] value);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic sender_gap(input int pct);
      if ($urandom_range(99) < pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic issue_random(input int tick_pct);
      mcstp_op_type           op;
      logic [CHANNEL_BITS-1:0] ch;
      logic [PERIOD_BITS-1:0] per;
      int                     r;
      r = $urandom_range(99);
      if (r < tick_pct) op = OP_TICK;
      else if (r < tick_pct + 15) op = OP_ALLOC;
      else if (r < tick_pct + 17) op = OP_CLEAR;
      else op = OP_POLL;
      r = $urandom_range(99);
      if (r < 55) ch = CHANNEL_BITS'($urandom_range(0, 3));
      else if (r < 88) ch = CHANNEL_BITS'($urandom_range(0, 31));
      else ch = CHANNEL_BITS'($urandom_range(32, 127));
      r = $urandom_range(99);
      if (r < 70) per = PERIOD_BITS'($urandom_range(0, 4));
      else if (r < 90) per = PERIOD_BITS'($urandom);
      else per = ($urandom_range(1)) ? 16'hFFFF : 16'h0000;
      issue(op, ch, 1'($urandom_range(1)), per);
   endtask

   task automatic run_phase(input logic [PRESCALE_BITS-1:0] limit, input int idle_pct,
                            input int tick_pct, input int count);
      int n;
      write_limit(limit);
      for (n = 0; n < count; n++) begin
         if (n == count / 2) drain();
         issue_random(tick_pct);
         sender_gap(idle_pct);
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      issue(OP_POLL, 7'd0, 1'b0, 16'd5);
      issue(OP_ALLOC, 7'd0, 1'b0, 16'd0);
      issue(OP_TICK, 7'd0, 1'b0, 16'd0);
      issue(OP_TICK, 7'd0, 1'b0, 16'd0);
      write_limit(8'd0);
      issue(OP_TICK, 7'd0, 1'b0, 16'd0);
      issue(OP_POLL, 7'd0, 1'b0, 16'd0);
      issue(OP_POLL, 7'd31, 1'b1, 16'd1);
      issue(OP_POLL, 7'd32, 1'b1, 16'd0);
      issue(OP_POLL, 7'd127, 1'b1, 16'hFFFF);
      issue(OP_POLL, 7'd1, 1'b0, 16'hFFFF);
      issue(OP_POLL, 7'd1, 1'b0, 16'hFFFF);
      issue(OP_TICK, 7'd127, 1'b1, 16'hFFFF);
      issue(OP_POLL, 7'd1, 1'b1, 16'h0000);
      issue(OP_POLL, 7'd5, 1'b1, 16'd2);
      issue(OP_TICK, 7'd0, 1'b0, 16'd0);
      issue(OP_POLL, 7'd5, 1'b1, 16'd2);
      issue(OP_POLL, 7'd5, 1'b0, 16'd2);
      issue(OP_CLEAR, 7'h55, 1'b1, 16'hAAAA);
      issue(OP_ALLOC, 7'h2A, 1'b0, 16'h5555);
      issue(OP_ALLOC, 7'd0, 1'b0, 16'd0);
      issue(OP_POLL, 7'd0, 1'b0, 16'd1);

      run_phase(8'd2, 12, 30, 200);
      run_phase(8'd1, 54, 30, 200);
      run_phase(8'd255, 0, 92, 150);
      run_phase(8'($urandom_range(3, 8)), 0, 35, 100);

      drain();
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
